[rtl/actuator_step_sequencer_macros.svh]
// Assertion helpers for the actuator step sequencer.
`ifndef ACTUATOR_STEP_SEQUENCER_MACROS_SVH
`define ACTUATOR_STEP_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/asq_pkg.sv]
package asq_pkg;

	localparam int ASQ_MAX_STEPS_DEF    = 16;
	localparam int ASQ_MAX_MACHINES_DEF = 8;

	localparam int OP_W     = 3;
	localparam int MACH_W   = 3;
	localparam int STATE_W  = 8;
	localparam int ENV_W    = 32;
	localparam int ACT_W    = 8;
	localparam int DELAY_W  = 32;
	localparam int DELTA_W  = 16;
	localparam int CMD_W    = 2;
	localparam int STAT_W   = 2;
	localparam int IDX_W    = 5;
	localparam int MACH_NUM = 2 ** MACH_W;

	localparam logic [OP_W-1:0] OP_ADD_MOTOR  = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_ACTION = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_IDLE   = 3'd2;
	localparam logic [OP_W-1:0] OP_START      = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;
	localparam logic [OP_W-1:0] OP_TICK       = 3'd5;

	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_IDLE   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_ACTION = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STAT_STEP_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_IDLE_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_START_EMPTY = 2'd3;

	localparam logic KIND_MOTOR  = 1'b0;
	localparam logic KIND_ACTION = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic [MACH_W-1:0]  machine;
		logic [STATE_W-1:0] state_code;
		logic [ENV_W-1:0]   env_word;
		logic [ACT_W-1:0]   action_id;
		logic [DELAY_W-1:0] delay_ms;
		logic [DELTA_W-1:0] delta_ms;
		logic [MACH_NUM-1:0] busy_mask;
	} asq_item_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [MACH_W-1:0]  cmd_machine;
		logic [STATE_W-1:0] cmd_state;
		logic [ENV_W-1:0]   cmd_env;
		logic [ACT_W-1:0]   cmd_action;
		logic [STAT_W-1:0]  status;
		logic               running;
		logic [IDX_W-1:0]   step_index;
	} asq_res_t;

endpackage

[rtl/asq_chan_if.sv]
interface asq_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/actuator_step_sequencer.sv]
// Actuator step sequencer. Each beat on item is one call (add motor step, add action step,
// register idle command, start, clear steps, tick) and yields exactly one beat on result.
// Each item passes through ST_IDLE, ST_READ and ST_EXEC: the cycle that accepts it also reads
// the step table and the per-step done/elapsed memory at the current step, ST_READ reads the
// idle-command memory at the step's machine, and ST_EXEC updates state and loads the output
// register, which offers the result. No item is taken before the previous one leaves ST_EXEC.
// A new item is accepted as soon as the sequencer is back in idle, even while the previous
// result still sits in the output register; the update cycle then holds until that result is
// taken. All memories are single-port with registered read data; no clearing pass is needed
// after reset.
`include "actuator_step_sequencer_macros.svh"

module actuator_step_sequencer
	import asq_pkg::*;
#(
	parameter int MAX_STEPS    = ASQ_MAX_STEPS_DEF,
	parameter int MAX_MACHINES = ASQ_MAX_MACHINES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	asq_chan_if.sink   item,
	asq_chan_if.source result
);

	localparam int CW = $clog2(MAX_STEPS + 1);
	localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int IW = $clog2(MAX_MACHINES + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	typedef struct packed {
		logic               kind;
		logic [MACH_W-1:0]  machine;
		logic [STATE_W-1:0] state_code;
		logic [ENV_W-1:0]   env_word;
		logic [ACT_W-1:0]   action_id;
		logic [DELAY_W-1:0] delay_ms;
	} step_ent_t;

	typedef struct packed {
		logic               done;
		logic [DELAY_W-1:0] elapsed;
	} dyn_ent_t;

	typedef struct packed {
		logic [STATE_W-1:0] state_code;
		logic [ENV_W-1:0]   env_word;
	} idle_ent_t;

	step_ent_t step_mem [MAX_STEPS];
	dyn_ent_t  dyn_mem  [MAX_STEPS];
	idle_ent_t idle_mem [MACH_NUM];

	state_t              state_q;
	asq_item_t           item_s1;
	step_ent_t           stp_rd_s1;
	dyn_ent_t            dyn_rd_s1;
	idle_ent_t           idl_rd_s2;
	logic [MACH_NUM-1:0] idle_vld_q;
	logic [CW-1:0]       total_q;
	logic [CW-1:0]       cur_q;
	logic [IW-1:0]       itot_q;
	logic                active_q;
	logic                sent_q;
	asq_res_t            res_q;
	logic                res_vq;

	logic          accept;
	logic          exec_go;
	logic [CW-1:0] total_n;
	logic [CW-1:0] cur_n;
	logic [IW-1:0] itot_n;
	logic          active_n;
	logic          sent_n;
	logic          stp_we;
	logic          dyn_we;
	logic [AW-1:0] dyn_wa;
	dyn_ent_t      dyn_wd;
	logic          idl_we;
	asq_res_t      res_n;
	step_ent_t     stp_wd;
	logic [MACH_W-1:0]  mach;
	logic [DELAY_W:0]   sum_w;
	logic [DELAY_W-1:0] sum_sat;
	logic               advance;
	logic               wait_w;

	assign accept      = item.valid && item.ready;
	assign item.ready  = (state_q == ST_IDLE);
	assign exec_go     = (state_q == ST_EXEC) && (!res_vq || result.ready);
	assign result.valid = res_vq;
	assign result.data  = res_q;

	assign mach    = stp_rd_s1.machine;
	assign sum_w   = {1'b0, dyn_rd_s1.elapsed} + (DELAY_W + 1)'(item_s1.delta_ms);
	assign sum_sat = sum_w[DELAY_W] ? '1 : sum_w[DELAY_W-1:0];

	always_comb begin
		stp_wd.kind       = (item_s1.opcode == OP_ADD_MOTOR) ? KIND_MOTOR : KIND_ACTION;
		stp_wd.machine    = item_s1.machine;
		stp_wd.state_code = item_s1.state_code;
		stp_wd.env_word   = item_s1.env_word;
		stp_wd.action_id  = item_s1.action_id;
		stp_wd.delay_ms   = item_s1.delay_ms;
	end

	always_comb begin
		total_n  = total_q;
		cur_n    = cur_q;
		itot_n   = itot_q;
		active_n = active_q;
		sent_n   = sent_q;
		stp_we   = 1'b0;
		dyn_we   = 1'b0;
		dyn_wa   = cur_q[AW-1:0];
		dyn_wd   = dyn_rd_s1;
		idl_we   = 1'b0;
		advance  = 1'b0;
		wait_w   = 1'b1;
		res_n    = '0;
		case (item_s1.opcode)
			OP_ADD_MOTOR, OP_ADD_ACTION: begin
				if (total_q >= CW'(MAX_STEPS)) begin
					res_n.status = STAT_STEP_FULL;
				end else begin
					stp_we  = 1'b1;
					dyn_we  = 1'b1;
					dyn_wa  = total_q[AW-1:0];
					dyn_wd  = '0;
					total_n = total_q + CW'(1);
				end
			end
			OP_SET_IDLE: begin
				if (itot_q >= IW'(MAX_MACHINES)) begin
					res_n.status = STAT_IDLE_FULL;
				end else begin
					itot_n = itot_q + IW'(1);
					idl_we = !idle_vld_q[item_s1.machine];
				end
			end
			OP_START: begin
				if (total_q == '0) begin
					res_n.status = STAT_START_EMPTY;
				end else begin
					cur_n    = '0;
					active_n = 1'b1;
					sent_n   = 1'b0;
				end
			end
			OP_CLEAR: begin
				total_n  = '0;
				cur_n    = '0;
				active_n = 1'b0;
				sent_n   = 1'b0;
			end
			OP_TICK: begin
				if (active_q) begin
					if (cur_q >= total_q) begin
						active_n = 1'b0;
					end else if (stp_rd_s1.kind == KIND_MOTOR) begin
						if (!sent_q) begin
							res_n.command     = CMD_STEP;
							res_n.cmd_machine = mach;
							res_n.cmd_state   = stp_rd_s1.state_code;
							res_n.cmd_env     = stp_rd_s1.env_word;
							sent_n            = 1'b1;
						end else if (!item_s1.busy_mask[mach]) begin
							if (idle_vld_q[mach]) begin
								res_n.command     = CMD_IDLE;
								res_n.cmd_machine = mach;
								res_n.cmd_state   = idl_rd_s2.state_code;
								res_n.cmd_env     = idl_rd_s2.env_word;
							end
							advance = 1'b1;
						end
					end else begin
						if (!dyn_rd_s1.done) begin
							res_n.command    = CMD_ACTION;
							res_n.cmd_action = stp_rd_s1.action_id;
							dyn_we           = 1'b1;
							dyn_wd.done      = 1'b1;
							if (stp_rd_s1.delay_ms == '0) begin
								advance = 1'b1;
								wait_w  = 1'b0;
							end
						end
						if (wait_w) begin
							dyn_we         = 1'b1;
							dyn_wd.elapsed = sum_sat;
							if (sum_sat >= stp_rd_s1.delay_ms) begin
								advance = 1'b1;
							end
						end
					end
					if (advance) begin
						cur_n  = cur_q + CW'(1);
						sent_n = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		res_n.running    = active_n;
		res_n.step_index = IDX_W'(cur_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= '0;
			cur_q      <= '0;
			itot_q     <= '0;
			active_q   <= 1'b0;
			sent_q     <= 1'b0;
			idle_vld_q <= '0;
			res_vq     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec_go) begin
				total_q  <= total_n;
				cur_q    <= cur_n;
				itot_q   <= itot_n;
				active_q <= active_n;
				sent_q   <= sent_n;
				if (idl_we) begin
					idle_vld_q[item_s1.machine] <= 1'b1;
				end
				res_vq <= 1'b1;
			end else if (result.ready) begin
				res_vq <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item.data;
		end
		if (exec_go) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && stp_we) begin
			step_mem[total_q[AW-1:0]] <= stp_wd;
		end
		if (accept) begin
			stp_rd_s1 <= step_mem[cur_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && dyn_we) begin
			dyn_mem[dyn_wa] <= dyn_wd;
		end
		if (accept) begin
			dyn_rd_s1 <= dyn_mem[cur_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && idl_we) begin
			idle_mem[item_s1.machine] <= '{state_code: item_s1.state_code,
				env_word: item_s1.env_word};
		end
		if (state_q == ST_READ) begin
			idl_rd_s2 <= idle_mem[stp_rd_s1.machine];
		end
	end

	`ASQ_ASSERT_IMP(a_total_bound, clk, arst_n, 1'b1, total_q <= CW'(MAX_STEPS), "steps over cap")
	`ASQ_ASSERT_IMP(a_cur_bound, clk, arst_n, active_q, cur_q <= total_q, "index past count")
	`ASQ_ASSERT_IMP(a_sent_active, clk, arst_n, sent_q, active_q, "step sent while stopped")
	`ASQ_ASSERT_NXT(a_res_from_exec, clk, arst_n, !exec_go && !res_vq, !res_vq, "stray result")

endmodule
